// ----- hdl/fvd_pkg.sv -----
package fvd_pkg;

    localparam int IN_W       = 40;
    localparam int ID_W       = 11;
    localparam int OUT_DIGITS = 6;
    localparam int CFG_IDX_W  = 1;

    // register indexes on the configuration port
    localparam logic [CFG_IDX_W-1:0] REG_FX_ID = 1'd0;
    localparam logic [CFG_IDX_W-1:0] REG_FY_ID = 1'd1;

    localparam logic [ID_W-1:0] FX_ID_RESET = 11'd256;
    localparam logic [ID_W-1:0] FY_ID_RESET = 11'd257;

    // clamp points of the 16-bit integer part
    localparam logic [15:0] INT_LIMIT = 16'h8000;
    localparam logic [15:0] INT_MAX   = 16'h7FFF;

    typedef struct packed {
        logic                   axis;
        logic signed [IN_W-1:0] force_value;
    } in_t;

    typedef struct packed {
        logic [ID_W-1:0] frame_id;
        logic [7:0]      int_high;
        logic [7:0]      int_low;
        logic [3:0]      digit_tenths;
        logic [3:0]      digit_hundredths;
        logic [3:0]      digit_thousandths;
        logic [3:0]      digit_fourth;
        logic [3:0]      digit_fifth;
        logic [3:0]      digit_sixth;
        logic            saturated;
    } out_t;

    typedef struct packed {
        logic            neg;
        logic [ID_W-1:0] frame_id;
    } meta_t;

    typedef struct packed {
        logic [ID_W-1:0] frame_id;
        logic [15:0]     int_word;
        logic            saturated;
    } side_t;

    typedef logic [OUT_DIGITS-1:0][3:0] digits_t;

    // elaboration-time helpers only
    function automatic logic [63:0] dec_pow(input int n);
        logic [63:0] p;
        p = 64'd1;
        for (int i = 0; i < n; i++) begin
            p = p * 64'd10;
        end
        return p;
    endfunction

    // bits for 0 .. 10**dc inclusive
    function automatic int scale_w(input int dc);
        return $clog2(dec_pow(dc) + 64'd1);
    endfunction

    // bits for 0 .. 10**dc - 1
    function automatic int frac_w(input int dc);
        return $clog2(dec_pow(dc));
    endfunction

endpackage

// ----- hdl/force_value_decimal_frame_encoder_core.sv -----
// Force sample to CAN payload encoder. Each accepted word is a signed fixed point
// force (FRAC_BITS fractional bits) and an axis select; the block rounds it half
// away from zero to DIGIT_COUNT decimal places and returns the axis frame id, the
// integer part as a big-endian 16-bit two's-complement value, six fraction digits
// and a saturation flag. It takes one sample per clock unless the output stalls,
// and returns results in order through two stages for magnitude and the
// fraction-times-10**DIGIT_COUNT multiply, two for rounding and clamping, and one
// stage for each of the six decimal digits. Every stage holds under backpressure,
// so no sample is dropped or repeated. The two frame ids are to be written through
// the cfg port only while the pipeline is empty; the block does not enforce this.
module force_value_decimal_frame_encoder_core
    import fvd_pkg::*;
#(
    parameter int FRAC_BITS   = 24,
    parameter int DIGIT_COUNT = 6
) (
    input  logic                 aclk,
    input  logic                 aresetn,
    input  logic                 s_valid,
    output logic                 s_ready,
    input  in_t                  s_data,
    output logic                 m_valid,
    input  logic                 m_ready,
    output out_t                 m_data,
    input  logic                 cfg_we,
    input  logic [CFG_IDX_W-1:0] cfg_addr,
    input  logic [ID_W-1:0]      cfg_wdata
);

    localparam int SCALE_W = scale_w(DIGIT_COUNT);
    localparam int FRAC_W  = frac_w(DIGIT_COUNT);
    localparam int IPART_W = IN_W - FRAC_BITS;

    logic [ID_W-1:0] fx_id_reg;
    logic [ID_W-1:0] fy_id_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            fx_id_reg <= FX_ID_RESET;
            fy_id_reg <= FY_ID_RESET;
        end else if (cfg_we) begin
            case (cfg_addr)
                REG_FX_ID: fx_id_reg <= cfg_wdata;
                REG_FY_ID: fy_id_reg <= cfg_wdata;
                default: ;
            endcase
        end
    end

    logic                         fr_valid;
    logic                         fr_ready;
    meta_t                        fr_meta;
    logic [IPART_W-1:0]           fr_ipart;
    logic [FRAC_BITS+SCALE_W-1:0] fr_prod;

    logic    dg_valid  [0:OUT_DIGITS];
    logic    dg_ready  [0:OUT_DIGITS];
    side_t   dg_side   [0:OUT_DIGITS];
    logic [FRAC_W-1:0] dg_rem [0:OUT_DIGITS];
    digits_t dg_digits [0:OUT_DIGITS];

    fvd_front #(
        .FRAC_BITS   (FRAC_BITS),
        .DIGIT_COUNT (DIGIT_COUNT)
    ) u_front (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .in_valid  (s_valid),
        .in_ready  (s_ready),
        .in_data   (s_data),
        .fx_id     (fx_id_reg),
        .fy_id     (fy_id_reg),
        .out_valid (fr_valid),
        .out_ready (fr_ready),
        .out_meta  (fr_meta),
        .out_ipart (fr_ipart),
        .out_prod  (fr_prod)
    );

    fvd_round #(
        .FRAC_BITS   (FRAC_BITS),
        .DIGIT_COUNT (DIGIT_COUNT)
    ) u_round (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .in_valid  (fr_valid),
        .in_ready  (fr_ready),
        .in_meta   (fr_meta),
        .in_ipart  (fr_ipart),
        .in_prod   (fr_prod),
        .out_valid (dg_valid[0]),
        .out_ready (dg_ready[0]),
        .out_side  (dg_side[0]),
        .out_frac  (dg_rem[0])
    );

    assign dg_digits[0] = '0;

    for (genvar k = 0; k < OUT_DIGITS; k++) begin : g_digit
        fvd_digit #(
            .DIGIT_COUNT (DIGIT_COUNT),
            .POS         (k)
        ) u_digit (
            .aclk       (aclk),
            .aresetn    (aresetn),
            .in_valid   (dg_valid[k]),
            .in_ready   (dg_ready[k]),
            .in_side    (dg_side[k]),
            .in_rem     (dg_rem[k]),
            .in_digits  (dg_digits[k]),
            .out_valid  (dg_valid[k+1]),
            .out_ready  (dg_ready[k+1]),
            .out_side   (dg_side[k+1]),
            .out_rem    (dg_rem[k+1]),
            .out_digits (dg_digits[k+1])
        );
    end

    assign m_valid                = dg_valid[OUT_DIGITS];
    assign dg_ready[OUT_DIGITS]   = m_ready;

    always_comb begin
        m_data.frame_id          = dg_side[OUT_DIGITS].frame_id;
        m_data.int_high          = dg_side[OUT_DIGITS].int_word[15:8];
        m_data.int_low           = dg_side[OUT_DIGITS].int_word[7:0];
        m_data.digit_tenths      = dg_digits[OUT_DIGITS][0];
        m_data.digit_hundredths  = dg_digits[OUT_DIGITS][1];
        m_data.digit_thousandths = dg_digits[OUT_DIGITS][2];
        m_data.digit_fourth      = dg_digits[OUT_DIGITS][3];
        m_data.digit_fifth       = dg_digits[OUT_DIGITS][4];
        m_data.digit_sixth       = dg_digits[OUT_DIGITS][5];
        m_data.saturated         = dg_side[OUT_DIGITS].saturated;
    end

    // remainder past the last digit is dropped
    logic unused_rem;
    assign unused_rem = ^dg_rem[OUT_DIGITS];

endmodule

// ----- hdl/fvd_front.sv -----
module fvd_front
    import fvd_pkg::*;
#(
    parameter int FRAC_BITS   = 24,
    parameter int DIGIT_COUNT = 6
) (
    input  logic                                      aclk,
    input  logic                                      aresetn,
    input  logic                                      in_valid,
    output logic                                      in_ready,
    input  in_t                                       in_data,
    input  logic [ID_W-1:0]                           fx_id,
    input  logic [ID_W-1:0]                           fy_id,
    output logic                                      out_valid,
    input  logic                                      out_ready,
    output meta_t                                     out_meta,
    output logic [IN_W-FRAC_BITS-1:0]                 out_ipart,
    output logic [FRAC_BITS+scale_w(DIGIT_COUNT)-1:0] out_prod
);

    localparam int          IPART_W = IN_W - FRAC_BITS;
    localparam int          SCALE_W = scale_w(DIGIT_COUNT);
    localparam int          PROD_W  = FRAC_BITS + SCALE_W;
    localparam logic [63:0] SCALE   = dec_pow(DIGIT_COUNT);

    logic              a_valid_reg;
    meta_t             a_meta_reg;
    logic [IN_W-1:0]   a_mag_reg;
    logic              b_valid_reg;
    meta_t             b_meta_reg;
    logic [IPART_W-1:0] b_ipart_reg;
    logic [PROD_W-1:0] b_prod_reg;

    logic              a_ready;
    logic              b_ready;
    meta_t             meta_next;
    logic [IN_W-1:0]   mag_next;
    logic [PROD_W-1:0] prod_next;

    assign b_ready  = !b_valid_reg || out_ready;
    assign a_ready  = !a_valid_reg || b_ready;
    assign in_ready = a_ready;

    always_comb begin
        meta_next.neg      = in_data.force_value[IN_W-1];
        meta_next.frame_id = in_data.axis ? fy_id : fx_id;
        // magnitude of the most negative sample is 2**39, still fits unsigned
        mag_next = meta_next.neg ? (IN_W'(0) - $unsigned(in_data.force_value))
                                 : $unsigned(in_data.force_value);
        prod_next = PROD_W'(a_mag_reg[FRAC_BITS-1:0]) * PROD_W'(SCALE);
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            a_valid_reg <= 1'b0;
            b_valid_reg <= 1'b0;
        end else begin
            if (a_ready) begin
                a_valid_reg <= in_valid;
            end
            if (b_ready) begin
                b_valid_reg <= a_valid_reg;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (a_ready && in_valid) begin
            a_meta_reg <= meta_next;
            a_mag_reg  <= mag_next;
        end
        if (b_ready && a_valid_reg) begin
            b_meta_reg  <= a_meta_reg;
            b_ipart_reg <= a_mag_reg[IN_W-1:FRAC_BITS];
            b_prod_reg  <= prod_next;
        end
    end

    assign out_valid = b_valid_reg;
    assign out_meta  = b_meta_reg;
    assign out_ipart = b_ipart_reg;
    assign out_prod  = b_prod_reg;

endmodule

// ----- hdl/fvd_round.sv -----
module fvd_round
    import fvd_pkg::*;
#(
    parameter int FRAC_BITS   = 24,
    parameter int DIGIT_COUNT = 6
) (
    input  logic                                      aclk,
    input  logic                                      aresetn,
    input  logic                                      in_valid,
    output logic                                      in_ready,
    input  meta_t                                     in_meta,
    input  logic [IN_W-FRAC_BITS-1:0]                 in_ipart,
    input  logic [FRAC_BITS+scale_w(DIGIT_COUNT)-1:0] in_prod,
    output logic                                      out_valid,
    input  logic                                      out_ready,
    output side_t                                     out_side,
    output logic [frac_w(DIGIT_COUNT)-1:0]            out_frac
);

    localparam int          IPART_W = IN_W - FRAC_BITS;
    localparam int          INT_W   = IPART_W + 1;
    localparam int          EXT_W   = INT_W + 16;
    localparam int          SCALE_W = scale_w(DIGIT_COUNT);
    localparam int          FRAC_W  = frac_w(DIGIT_COUNT);
    localparam int          PROD_W  = FRAC_BITS + SCALE_W;
    localparam logic [63:0] SCALE   = dec_pow(DIGIT_COUNT);

    logic              c_valid_reg;
    meta_t             c_meta_reg;
    logic [INT_W-1:0]  c_int_reg;
    logic [FRAC_W-1:0] c_frac_reg;
    logic              d_valid_reg;
    side_t             d_side_reg;
    logic [FRAC_W-1:0] d_frac_reg;

    logic               c_ready;
    logic               d_ready;
    logic [PROD_W-1:0]  rounded;
    logic [SCALE_W-1:0] fround;
    logic               carry;
    logic [INT_W-1:0]   int_next;
    logic [FRAC_W-1:0]  frac_next;
    logic [EXT_W-1:0]   int_ext;
    logic               ovf;
    logic [15:0]        mag16;
    side_t              side_next;
    logic [FRAC_W-1:0]  frac_sat_next;

    assign d_ready  = !d_valid_reg || out_ready;
    assign c_ready  = !c_valid_reg || d_ready;
    assign in_ready = c_ready;

    always_comb begin
        // half away from zero on the magnitude
        rounded   = in_prod + (PROD_W'(1) << (FRAC_BITS - 1));
        fround    = rounded[PROD_W-1:FRAC_BITS];
        carry     = (fround == SCALE_W'(SCALE));
        int_next  = INT_W'(in_ipart) + INT_W'(carry);
        frac_next = carry ? '0 : fround[FRAC_W-1:0];

        int_ext = EXT_W'(c_int_reg);
        if (c_meta_reg.neg) begin
            ovf = int_ext > EXT_W'(INT_LIMIT);
        end else begin
            ovf = int_ext >= EXT_W'(INT_LIMIT);
        end
        if (ovf) begin
            mag16 = c_meta_reg.neg ? INT_LIMIT : INT_MAX;
        end else begin
            mag16 = int_ext[15:0];
        end
        side_next.frame_id  = c_meta_reg.frame_id;
        side_next.int_word  = c_meta_reg.neg ? (16'd0 - mag16) : mag16;
        side_next.saturated = ovf;
        frac_sat_next       = ovf ? FRAC_W'(SCALE - 64'd1) : c_frac_reg;
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            c_valid_reg <= 1'b0;
            d_valid_reg <= 1'b0;
        end else begin
            if (c_ready) begin
                c_valid_reg <= in_valid;
            end
            if (d_ready) begin
                d_valid_reg <= c_valid_reg;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (c_ready && in_valid) begin
            c_meta_reg <= in_meta;
            c_int_reg  <= int_next;
            c_frac_reg <= frac_next;
        end
        if (d_ready && c_valid_reg) begin
            d_side_reg <= side_next;
            d_frac_reg <= frac_sat_next;
        end
    end

    assign out_valid = d_valid_reg;
    assign out_side  = d_side_reg;
    assign out_frac  = d_frac_reg;

endmodule

// ----- hdl/fvd_digit.sv -----
module fvd_digit
    import fvd_pkg::*;
#(
    parameter int DIGIT_COUNT = 6,
    parameter int POS         = 0
) (
    input  logic                           aclk,
    input  logic                           aresetn,
    input  logic                           in_valid,
    output logic                           in_ready,
    input  side_t                          in_side,
    input  logic [frac_w(DIGIT_COUNT)-1:0] in_rem,
    input  digits_t                        in_digits,
    output logic                           out_valid,
    input  logic                           out_ready,
    output side_t                          out_side,
    output logic [frac_w(DIGIT_COUNT)-1:0] out_rem,
    output digits_t                        out_digits
);

    localparam int          FRAC_W = frac_w(DIGIT_COUNT);
    localparam bit          ACTIVE = (POS < DIGIT_COUNT);
    // weight of this digit; unused past the last digit
    localparam logic [63:0] STEP   = ACTIVE ? dec_pow(DIGIT_COUNT - 1 - POS) : 64'd1;

    logic              valid_reg;
    side_t             side_reg;
    logic [FRAC_W-1:0] rem_reg;
    digits_t           digits_reg;

    logic              stage_ready;
    logic [3:0]        digit;
    logic [FRAC_W-1:0] sub;
    digits_t           digits_next;

    assign stage_ready = !valid_reg || out_ready;
    assign in_ready    = stage_ready;

    // thresholds are independent compares, the largest one passed gives the digit
    always_comb begin
        digit = 4'd0;
        sub   = '0;
        for (int m = 1; m <= 9; m++) begin
            if (ACTIVE && (64'(in_rem) >= STEP * 64'(m))) begin
                digit = 4'(m);
                sub   = FRAC_W'(STEP * 64'(m));
            end
        end
        digits_next      = in_digits;
        digits_next[POS] = digit;
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            valid_reg <= 1'b0;
        end else if (stage_ready) begin
            valid_reg <= in_valid;
        end
    end

    always_ff @(posedge aclk) begin
        if (stage_ready && in_valid) begin
            side_reg   <= in_side;
            rem_reg    <= in_rem - sub;
            digits_reg <= digits_next;
        end
    end

    assign out_valid  = valid_reg;
    assign out_side   = side_reg;
    assign out_rem    = rem_reg;
    assign out_digits = digits_reg;

endmodule

// ----- hdl/fvd_checker.sv -----
module fvd_props
    import fvd_pkg::*;
(
    input logic                 aclk,
    input logic                 aresetn,
    input logic                 s_valid,
    input logic                 s_ready,
    input in_t                  s_data,
    input logic                 m_valid,
    input logic                 m_ready,
    input out_t                 m_data,
    input logic                 cfg_we,
    input logic [CFG_IDX_W-1:0] cfg_addr,
    input logic [ID_W-1:0]      cfg_wdata
);

    // ten register stages between the ports
    localparam int          DEPTH = 10;
    localparam int          CNT_W = $clog2(DEPTH + 1);

    logic [CNT_W-1:0] inflight_reg;
    logic [CNT_W-1:0] inflight_next;
    logic             s_fire;
    logic             m_fire;
    logic             unused_in;

    assign s_fire    = s_valid && s_ready;
    assign m_fire    = m_valid && m_ready;
    assign unused_in = ^{s_data, cfg_we, cfg_addr, cfg_wdata};

    always_comb begin
        inflight_next = inflight_reg;
        if (s_fire && !m_fire) begin
            inflight_next = inflight_reg + CNT_W'(1);
        end else if (m_fire && !s_fire) begin
            inflight_next = inflight_reg - CNT_W'(1);
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            inflight_reg <= '0;
        end else begin
            inflight_reg <= inflight_next;
        end
    end

    // a held result keeps its word
    a_out_hold: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && !m_ready |=> m_valid && $stable(m_data))
        else $error("result word changed while stalled");

    // no result without a sample behind it; the bound on samples in flight is a_depth
    a_no_invent: assert property (@(posedge aclk) disable iff (!aresetn)
        inflight_reg == '0 |-> !m_valid && inflight_reg <= CNT_W'(DEPTH))
        else $error("result without an accepted sample");

    a_depth: assert property (@(posedge aclk) disable iff (!aresetn)
        inflight_reg <= CNT_W'(DEPTH))
        else $error("more samples in flight than pipeline stages");

    a_digits: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid |-> m_data.digit_tenths <= 4'd9 && m_data.digit_hundredths <= 4'd9 &&
                    m_data.digit_thousandths <= 4'd9 && m_data.digit_fourth <= 4'd9 &&
                    m_data.digit_fifth <= 4'd9 && m_data.digit_sixth <= 4'd9)
        else $error("fraction digit out of decimal range");

    a_sat_clamp: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && m_data.saturated |->
            (m_data.int_high == 8'h7F && m_data.int_low == 8'hFF) ||
            (m_data.int_high == 8'h80 && m_data.int_low == 8'h00))
        else $error("saturated result not at a clamp value");

endmodule

bind force_value_decimal_frame_encoder_core fvd_props u_fvd_checker (.*);
